FILE: rtl/lrpm_pkg.sv
// Shared types and constants of the link rate peak meter.
package lrpm_pkg;

    localparam int COUNTER_WIDTH = 64;
    localparam logic [63:0] CNT_MASK = {64{1'b1}} >> (64 - COUNTER_WIDTH);

    localparam logic [63:0] MIN_ELAPSED_MS = 64'd100;
    localparam logic [16:0] MUL_RATE       = 17'd1000;
    localparam logic [16:0] MUL_SHARE      = 17'd100000;
    localparam logic [16:0] MUL_LINK       = 17'd2;
    localparam logic [13:0] FULL_SHARE     = 14'd10000;
    localparam logic [19:0] LINK_SHARE_MAX = 20'd1000000;
    // reciprocal of ten, exact for values below 2^18
    localparam logic [16:0] RECIP_TEN      = 17'd104858;

    typedef enum logic [1:0] {
        KIND_FIRST  = 2'd0,
        KIND_IGNORE = 2'd1,
        KIND_UPDATE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        OP_RX_RATE  = 3'd0,
        OP_TX_RATE  = 3'd1,
        OP_RX_SHARE = 3'd2,
        OP_TX_SHARE = 3'd3,
        OP_RX_LINK  = 3'd4,
        OP_TX_LINK  = 3'd5
    } op_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic start;
        op_t  op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_done;
        logic  out_free;
    } stat_t;

endpackage

FILE: rtl/lrpm_div.sv
// Serial divider: floor(num/den) of an 81-bit numerator, one quotient bit a cycle, saturating.
module lrpm_div
    import lrpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [16:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] q_reg, q_next;
    logic [63:0] den_reg, den_next;
    logic        sat_reg, sat_next;
    logic [64:0] rem_sh;

    // Shift in one numerator bit and try the subtraction
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        sat_next  = sat_reg;
        rem_sh    = {rem_reg, lo_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = {47'd0, num_hi};
            lo_next   = num_lo;
            q_next    = 64'd0;
            den_next  = den;
            sat_next  = ({47'd0, num_hi} >= den);
        end
        else if (busy_reg)
        begin
            lo_next = {lo_reg[62:0], 1'b0};
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = 64'(rem_sh - {1'b0, den_reg});
                q_next   = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[63:0];
                q_next   = {q_reg[62:0], 1'b0};
            end
            cnt_next = 6'(cnt_reg + 6'd1);
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quot = sat_reg ? {64{1'b1}} : q_reg;

endmodule

FILE: rtl/lrpm_dp.sv
// Datapath: sample and state registers, operand selection, result update and output word.
module lrpm_dp
    import lrpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    output stat_t        stat,
    input  logic [191:0] in_data,
    input  logic         cfg_valid,
    input  logic [19:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [327:0] m_tdata,
    output logic [1:0]   m_tuser
);

    logic [63:0]  cur_rx_reg, cur_tx_reg, cur_time_reg;
    logic [63:0]  last_rx_reg, last_tx_reg, last_time_reg;
    logic [63:0]  rxr_reg, txr_reg;
    logic [63:0]  rx_rate_reg, tx_rate_reg, rx_peak_reg, tx_peak_reg;
    logic [13:0]  rx_share_reg, tx_share_reg;
    logic [19:0]  rx_link_reg, tx_link_reg;
    logic [19:0]  speed_reg;
    kind_t        kind_reg;
    op_t          op_reg;
    logic         mv_reg;
    logic [327:0] mdata_reg;
    logic [1:0]   muser_reg;

    kind_t        kind_now;
    logic [63:0]  elapsed;
    logic [63:0]  opa, den;
    logic [16:0]  opb;
    logic [80:0]  prod;
    logic [63:0]  link_den;
    logic         div_done;
    logic [63:0]  quot;
    logic [17:0]  round_sum;
    logic [34:0]  tenth;
    logic [19:0]  link_val;

    // Classify the held sample against the stored time
    assign elapsed = cur_time_reg - last_time_reg;
    always_comb
    begin
        if (last_time_reg == 64'd0)
            kind_now = KIND_FIRST;
        else if (cur_time_reg < last_time_reg || elapsed < MIN_ELAPSED_MS)
            kind_now = KIND_IGNORE;
        else
            kind_now = KIND_UPDATE;
    end

    assign link_den = {44'd0, speed_reg} * 64'd25;

    // Select operands for the next division
    always_comb
    begin
        case (cmd.op)
            OP_RX_RATE:
            begin
                opa = (cur_rx_reg >= last_rx_reg) ? cur_rx_reg - last_rx_reg : 64'd0;
                opb = MUL_RATE;
                den = elapsed;
            end
            OP_TX_RATE:
            begin
                opa = (cur_tx_reg >= last_tx_reg) ? cur_tx_reg - last_tx_reg : 64'd0;
                opb = MUL_RATE;
                den = elapsed;
            end
            OP_RX_SHARE:
            begin
                opa = rxr_reg;
                opb = MUL_SHARE;
                den = rx_peak_reg;
            end
            OP_TX_SHARE:
            begin
                opa = txr_reg;
                opb = MUL_SHARE;
                den = tx_peak_reg;
            end
            OP_RX_LINK:
            begin
                opa = rx_rate_reg;
                opb = MUL_LINK;
                den = link_den;
            end
            default:
            begin
                opa = tx_rate_reg;
                opb = MUL_LINK;
                den = link_den;
            end
        endcase
        prod = {17'd0, opa} * {64'd0, opb};
    end

    lrpm_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .num_hi (prod[80:64]),
        .num_lo (prod[63:0]),
        .den    (den),
        .done   (div_done),
        .quot   (quot)
    );

    // Round the peak share to hundredths, clamp the link share and zero it without a link speed
    assign round_sum = 18'(quot[16:0]) + 18'd5;
    assign tenth     = {17'd0, round_sum} * {18'd0, RECIP_TEN};
    assign link_val  = (speed_reg == 20'd0) ? 20'd0 :
                       (quot > 64'(LINK_SHARE_MAX)) ? LINK_SHARE_MAX : quot[19:0];

    // Hold the link speed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            speed_reg <= 20'd0;
        else if (cfg_valid)
            speed_reg <= cfg_data;
    end

    // Update the measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_rx_reg   <= 64'd0;
            last_tx_reg   <= 64'd0;
            last_time_reg <= 64'd0;
            rx_rate_reg   <= 64'd0;
            tx_rate_reg   <= 64'd0;
            rx_peak_reg   <= 64'd0;
            tx_peak_reg   <= 64'd0;
            rx_share_reg  <= 14'd0;
            tx_share_reg  <= 14'd0;
            kind_reg      <= KIND_FIRST;
            op_reg        <= OP_RX_RATE;
        end
        else
        begin
            if (cmd.classify)
            begin
                kind_reg <= kind_now;
                if (kind_now == KIND_FIRST)
                begin
                    last_rx_reg   <= cur_rx_reg;
                    last_tx_reg   <= cur_tx_reg;
                    last_time_reg <= cur_time_reg;
                    rx_rate_reg   <= 64'd0;
                    tx_rate_reg   <= 64'd0;
                    rx_peak_reg   <= 64'd0;
                    tx_peak_reg   <= 64'd0;
                    rx_share_reg  <= 14'd0;
                    tx_share_reg  <= 14'd0;
                end
            end
            if (div_done)
            begin
                case (op_reg)
                    OP_TX_RATE:
                    begin
                        last_rx_reg   <= cur_rx_reg;
                        last_tx_reg   <= cur_tx_reg;
                        last_time_reg <= cur_time_reg;
                    end
                    OP_RX_SHARE:
                    begin
                        rx_rate_reg <= rxr_reg;
                        if (rx_peak_reg <= rxr_reg)
                        begin
                            rx_peak_reg  <= rxr_reg;
                            rx_share_reg <= FULL_SHARE;
                        end
                        else
                            rx_share_reg <= tenth[33:20];
                    end
                    OP_TX_SHARE:
                    begin
                        tx_rate_reg <= txr_reg;
                        if (tx_peak_reg <= txr_reg)
                        begin
                            tx_peak_reg  <= txr_reg;
                            tx_share_reg <= FULL_SHARE;
                        end
                        else
                            tx_share_reg <= tenth[33:20];
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.start)
                op_reg <= cmd.op;
        end
    end

    // Capture the sample, new rates and link shares
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_rx_reg   <= in_data[63:0] & CNT_MASK;
            cur_tx_reg   <= in_data[127:64] & CNT_MASK;
            cur_time_reg <= in_data[191:128];
        end
        if (div_done)
        begin
            case (op_reg)
                OP_RX_RATE: rxr_reg     <= quot;
                OP_TX_RATE: txr_reg     <= quot;
                OP_RX_LINK: rx_link_reg <= link_val;
                OP_TX_LINK: tx_link_reg <= link_val;
                default:
                begin
                end
            endcase
        end
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else if (cmd.emit)
            mv_reg <= 1'b1;
        else if (m_tready)
            mv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            mdata_reg <= {4'b0000, tx_link_reg, rx_link_reg, tx_share_reg, rx_share_reg,
                          tx_peak_reg, rx_peak_reg, tx_rate_reg, rx_rate_reg};
            muser_reg <= kind_reg;
        end
    end

    assign m_tvalid      = mv_reg;
    assign m_tdata       = mdata_reg;
    assign m_tuser       = muser_reg;
    assign stat.kind     = kind_reg;
    assign stat.div_done = div_done;
    assign stat.out_free = !mv_reg || m_tready;

endmodule

FILE: rtl/lrpm_ctrl.sv
// Controller: sequences classification, the divisions and the result hand-off.
module lrpm_ctrl
    import lrpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_START,
        S_WAIT,
        S_OUT
    } state_t;

    state_t state_reg;
    op_t    op_reg;
    logic   last_op;

    assign last_op = (op_reg == OP_TX_LINK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_RX_RATE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                    if (s_tvalid)
                        state_reg <= S_CLASS;
                S_CLASS:
                    state_reg <= S_START;
                S_START:
                begin
                    op_reg    <= (stat.kind == KIND_UPDATE) ? OP_RX_RATE : OP_RX_LINK;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                    if (stat.div_done)
                    begin
                        if (last_op)
                            state_reg <= S_OUT;
                        else
                            op_reg <= op_t'(op_reg + 3'd1);
                    end
                S_OUT:
                    if (stat.out_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Decode commands from the state
    always_comb
    begin
        cmd.load     = (state_reg == S_IDLE) && s_tvalid;
        cmd.classify = (state_reg == S_CLASS);
        cmd.emit     = (state_reg == S_OUT) && stat.out_free;
        cmd.start    = 1'b0;
        cmd.op       = op_reg;
        case (state_reg)
            S_START:
            begin
                cmd.start = 1'b1;
                cmd.op    = (stat.kind == KIND_UPDATE) ? OP_RX_RATE : OP_RX_LINK;
            end
            S_WAIT:
            begin
                cmd.start = stat.div_done && !last_op;
                cmd.op    = op_t'(op_reg + 3'd1);
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

FILE: rtl/link_rate_peak_meter.sv
// Top level of the link rate peak meter.
// One counter snapshot is processed at a time. An updating sample runs six
// divisions on one shared serial divider (rx and tx rate, rx and tx peak
// share, rx and tx link share) one after another; first and too-early
// samples run only the two link share divisions. A new sample is taken
// once the previous result has been loaded into the output register.
module link_rate_peak_meter
    import lrpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // rx_byte_total, tx_byte_total, sample_time_ms
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [19:0]  cfg_data,  // link_speed_mbps
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [327:0] m_tdata,   // rx_rate, tx_rate, rx_peak, tx_peak,
                                    // rx_peak_share, tx_peak_share, rx_link_share,
                                    // tx_link_share, zero pad
    output logic [1:0]   m_tuser    // sample_status
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    lrpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrpm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: rtl/lrpm_checker.sv
// Port-level checks of the link rate peak meter, bound to the top level.
module lrpm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [327:0] m_tdata,
    input logic [1:0]   m_tuser
);

    // one sample at a time: no new word right after one is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // peak shares never exceed full scale
    a_peak_share: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[269:256] <= 14'd10000 && m_tdata[283:270] <= 14'd10000)
        else $error("peak share out of range");

    // link shares saturate and status is a known kind
    a_link_share: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[303:284] <= 20'd1000000 && m_tdata[323:304] <= 20'd1000000
                     && m_tuser != 2'd3)
        else $error("link share or status out of range");

endmodule

bind link_rate_peak_meter lrpm_checker u_lrpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
